FILE: hw/rtl/mhe_pkg.sv
// Shared types, character constants and the entity-name ROM for the MacRoman HTML escaper.
// Used by every pipeline stage; depends on nothing else.
package mhe_pkg;

  localparam int RunBytes = 9;
  localparam int RunWordW = RunBytes * 8;
  localparam int RunLenW  = 4;

  localparam logic [7:0] ChAmp  = 8'h26;
  localparam logic [7:0] ChQuot = 8'h22;
  localparam logic [7:0] ChLt   = 8'h3C;
  localparam logic [7:0] ChGt   = 8'h3E;

  typedef logic [RunWordW-1:0] run_word_t;

  // Raw expansion after the ROM, right-justified: last character in the lowest byte.
  typedef struct packed {
    run_word_t word;
    logic      pass;
    logic      text_end;
  } lk_t;

  // Expansion left-aligned: first character in the highest byte.
  typedef struct packed {
    run_word_t          word;
    logic [RunLenW-1:0] len;
    logic               text_end;
  } run_t;

  function automatic run_word_t rom_entity(input logic [6:0] idx);
    run_word_t w;
    case (idx)
      7'h00: w = run_word_t'("&Auml;");
      7'h01: w = run_word_t'("&Aring;");
      7'h02: w = run_word_t'("&Ccedil;");
      7'h03: w = run_word_t'("&Eacute;");
      7'h04: w = run_word_t'("&Ntilde;");
      7'h05: w = run_word_t'("&Ouml;");
      7'h06: w = run_word_t'("&Uuml;");
      7'h07: w = run_word_t'("&aacute;");
      7'h08: w = run_word_t'("&agrave;");
      7'h09: w = run_word_t'("&acirc;");
      7'h0A: w = run_word_t'("&auml;");
      7'h0B: w = run_word_t'("&atilde;");
      7'h0C: w = run_word_t'("&aring;");
      7'h0D: w = run_word_t'("&ccedil;");
      7'h0E: w = run_word_t'("&eacute;");
      7'h0F: w = run_word_t'("&egrave;");
      7'h10: w = run_word_t'("&ecirc;");
      7'h11: w = run_word_t'("&euml;");
      7'h12: w = run_word_t'("&iacute;");
      7'h13: w = run_word_t'("&igrave;");
      7'h14: w = run_word_t'("&icirc;");
      7'h15: w = run_word_t'("&iuml;");
      7'h16: w = run_word_t'("&ntilde;");
      7'h17: w = run_word_t'("&oacute;");
      7'h18: w = run_word_t'("&ograve;");
      7'h19: w = run_word_t'("&ocirc;");
      7'h1A: w = run_word_t'("&ouml;");
      7'h1B: w = run_word_t'("&otilde;");
      7'h1C: w = run_word_t'("&uacute;");
      7'h1D: w = run_word_t'("&ugrave;");
      7'h1E: w = run_word_t'("&ucirc;");
      7'h1F: w = run_word_t'("&uuml;");
      7'h20: w = run_word_t'("&dagger;");
      7'h21: w = run_word_t'("&deg;");
      7'h22: w = run_word_t'("&cent;");
      7'h23: w = run_word_t'("&pound;");
      7'h24: w = run_word_t'("&sect;");
      7'h25: w = run_word_t'("&bull;");
      7'h26: w = run_word_t'("&para;");
      7'h27: w = run_word_t'("&szlig;");
      7'h28: w = run_word_t'("&reg;");
      7'h29: w = run_word_t'("&copy;");
      7'h2A: w = run_word_t'("&trade;");
      7'h2B: w = run_word_t'("&acute;");
      7'h2C: w = run_word_t'("&uml;");
      7'h2D: w = run_word_t'("&ne;");
      7'h2E: w = run_word_t'("&AElig;");
      7'h2F: w = run_word_t'("&Oslash;");
      7'h30: w = run_word_t'("&infin;");
      7'h31: w = run_word_t'("&plusmn;");
      7'h32: w = run_word_t'("&le;");
      7'h33: w = run_word_t'("&ge;");
      7'h34: w = run_word_t'("&yen;");
      7'h35: w = run_word_t'("&micro;");
      7'h36: w = run_word_t'("&part;");
      7'h37: w = run_word_t'("&sum;");
      7'h38: w = run_word_t'("&product;");
      7'h39: w = run_word_t'("&pi;");
      7'h3A: w = run_word_t'("&int;");
      7'h3B: w = run_word_t'("&ordf;");
      7'h3C: w = run_word_t'("&ordm;");
      7'h3D: w = run_word_t'("&Omega;");
      7'h3E: w = run_word_t'("&aelig;");
      7'h3F: w = run_word_t'("&oslash;");
      7'h40: w = run_word_t'("&iquest;");
      7'h41: w = run_word_t'("&iexcl;");
      7'h42: w = run_word_t'("&not;");
      7'h43: w = run_word_t'("&radic;");
      7'h44: w = run_word_t'("&fnof;");
      7'h45: w = run_word_t'("&asymp;");
      7'h46: w = run_word_t'("&#x2206;");
      7'h47: w = run_word_t'("&laquo;");
      7'h48: w = run_word_t'("&raquo;");
      7'h49: w = run_word_t'("&hellip;");
      7'h4A: w = run_word_t'("&nbsp;");
      7'h4B: w = run_word_t'("&Agrave;");
      7'h4C: w = run_word_t'("&Atilde;");
      7'h4D: w = run_word_t'("&Otilde;");
      7'h4E: w = run_word_t'("&OElig;");
      7'h4F: w = run_word_t'("&oelig;");
      7'h50: w = run_word_t'("&ndash;");
      7'h51: w = run_word_t'("&mdash;");
      7'h52: w = run_word_t'("&ldquo;");
      7'h53: w = run_word_t'("&rdquo;");
      7'h54: w = run_word_t'("&lsquo;");
      7'h55: w = run_word_t'("&rsquo;");
      7'h56: w = run_word_t'("&divide;");
      7'h57: w = run_word_t'("&loz;");
      7'h58: w = run_word_t'("&yuml;");
      7'h59: w = run_word_t'("&Yuml;");
      7'h5A: w = run_word_t'("&frasl;");
      7'h5B: w = run_word_t'("&euro;");
      7'h5C: w = run_word_t'("&lsaquo;");
      7'h5D: w = run_word_t'("&rsaquo;");
      7'h5E: w = run_word_t'("&#xfb01;");
      7'h5F: w = run_word_t'("&#xfb02;");
      7'h60: w = run_word_t'("&Dagger;");
      7'h61: w = run_word_t'("&middot;");
      7'h62: w = run_word_t'("&sbquo;");
      7'h63: w = run_word_t'("&bdquo;");
      7'h64: w = run_word_t'("&permil;");
      7'h65: w = run_word_t'("&Acirc;");
      7'h66: w = run_word_t'("&Ecirc;");
      7'h67: w = run_word_t'("&Aacute;");
      7'h68: w = run_word_t'("&Euml;");
      7'h69: w = run_word_t'("&Egrave;");
      7'h6A: w = run_word_t'("&Iacute;");
      7'h6B: w = run_word_t'("&Icirc;");
      7'h6C: w = run_word_t'("&Iuml;");
      7'h6D: w = run_word_t'("&Igrave;");
      7'h6E: w = run_word_t'("&Oacute;");
      7'h6F: w = run_word_t'("&Ocirc;");
      7'h70: w = run_word_t'("&#xf8ff;");
      7'h71: w = run_word_t'("&Ograve;");
      7'h72: w = run_word_t'("&Uacute;");
      7'h73: w = run_word_t'("&Ucirc;");
      7'h74: w = run_word_t'("&Ugrave;");
      7'h75: w = run_word_t'("&#x0131;");
      7'h76: w = run_word_t'("&circ;");
      7'h77: w = run_word_t'("&tilde;");
      7'h78: w = run_word_t'("&macr;");
      7'h79: w = run_word_t'("&#x02d8;");
      7'h7A: w = run_word_t'("&#x02d9;");
      7'h7B: w = run_word_t'("&#x02da;");
      7'h7C: w = run_word_t'("&cedil;");
      7'h7D: w = run_word_t'("&#x02dd;");
      7'h7E: w = run_word_t'("&#x02db;");
      default: w = run_word_t'("&#x02c7;");
    endcase
    return w;
  endfunction

endpackage

FILE: hw/rtl/mhe_lookup.sv
// Lookup stage: maps one character to its right-justified expansion word.
// Depends on mhe_pkg for the entity ROM and the stage types.
module mhe_lookup (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         valid_i,
  input  logic [7:0]   byte_i,
  input  logic         end_i,
  output logic         stall_o,
  output logic         valid_o,
  output mhe_pkg::lk_t lk_o,
  input  logic         stall_i
);
  import mhe_pkg::*;

  logic valid_q;
  lk_t  lk_q, lk_d;

  always_comb begin
    lk_d.text_end = end_i;
    lk_d.pass     = 1'b0;
    if (byte_i[7]) begin
      lk_d.word = rom_entity(byte_i[6:0]);
    end else begin
      case (byte_i)
        ChAmp:   lk_d.word = run_word_t'("&amp;");
        ChQuot:  lk_d.word = run_word_t'("&quot;");
        ChLt:    lk_d.word = run_word_t'("&lt;");
        ChGt:    lk_d.word = run_word_t'("&gt;");
        default: begin
          lk_d.word = run_word_t'(byte_i);
          lk_d.pass = 1'b1;
        end
      endcase
    end
  end

  assign stall_o = valid_q & stall_i;
  assign valid_o = valid_q;
  assign lk_o    = lk_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      lk_q <= lk_d;
    end
  end

endmodule

FILE: hw/rtl/mhe_align.sv
// Align stage: measures the expansion and moves its first character to the top byte.
// Depends on mhe_pkg for the stage types.
module mhe_align (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mhe_pkg::lk_t  lk_i,
  output logic          stall_o,
  output logic          valid_o,
  output mhe_pkg::run_t run_o,
  input  logic          stall_i
);
  import mhe_pkg::*;

  logic               valid_q;
  run_t               run_q, run_d;
  logic [RunLenW-1:0] len;
  logic [RunLenW-1:0] shamt;

  // Names hold no zero bytes, so the highest non-zero byte marks the length.
  always_comb begin
    len = RunLenW'(1);
    if (!lk_i.pass) begin
      for (int k = 0; k < RunBytes; k++) begin
        if (lk_i.word[8*k +: 8] != 8'h00) begin
          len = RunLenW'(k + 1);
        end
      end
    end
    shamt          = RunLenW'(RunBytes) - len;
    run_d.word     = lk_i.word << {shamt, 3'b000};
    run_d.len      = len;
    run_d.text_end = lk_i.text_end;
  end

  assign stall_o = valid_q & stall_i;
  assign valid_o = valid_q;
  assign run_o   = run_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      run_q <= run_d;
    end
  end

endmodule

FILE: hw/rtl/mhe_serial.sv
// Serialiser: shifts an aligned expansion out one byte per cycle from its output register while out_stall_i is low.
// Depends on mhe_pkg for the stage types.
module mhe_serial (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  mhe_pkg::run_t run_i,
  output logic          stall_o,
  output logic          out_valid_o,
  output logic [7:0]    out_byte_o,
  output logic          run_last_o,
  output logic          text_last_o,
  input  logic          out_stall_i
);
  import mhe_pkg::*;

  logic               valid_q;
  run_word_t          word_q;
  logic [RunLenW-1:0] cnt_q;
  logic               end_q;
  logic               last;
  logic               take;
  logic               free;

  assign last = (cnt_q == RunLenW'(1));
  assign take = valid_q & ~out_stall_i;
  // The register can load a new run when empty or when its final byte leaves.
  assign free = ~valid_q | (take & last);

  assign stall_o     = ~free;
  assign out_valid_o = valid_q;
  assign out_byte_o  = word_q[RunWordW-1 -: 8];
  assign run_last_o  = last;
  assign text_last_o = last & end_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
      cnt_q   <= RunLenW'(1);
    end else if (free) begin
      valid_q <= valid_i;
      if (valid_i) begin
        cnt_q <= run_i.len;
      end
    end else if (take) begin
      cnt_q <= cnt_q - RunLenW'(1);
    end
  end

  always_ff @(posedge clk_i) begin
    if (free && valid_i) begin
      word_q <= run_i.word;
      end_q  <= run_i.text_end;
    end else if (take) begin
      word_q <= word_q << 8;
    end
  end

endmodule

FILE: hw/rtl/macroman_html_entity_escaper_core.sv
// MacRoman to HTML escaper: top level with input register, pipeline wiring and checks.
// Depends on mhe_pkg, mhe_lookup, mhe_align and mhe_serial.
//
// Usage. Each request on the text channel (text_valid_i, text_stall_o, text_byte_i,
// text_end_i) carries one MacRoman character. The out channel (out_valid_o, out_stall_i,
// out_byte_o, run_last_o, text_last_o) returns its HTML form as a run of one to nine
// bytes. Characters with the top bit set become '&', an entity name or a '#x' code, and ';'. The
// characters ampersand, double quote, less-than and greater-than become the usual named
// references, and every other byte passes through unchanged. run_last_o marks the final
// byte of each run, and text_last_o marks that byte when the request carried text_end_i.
// The first byte of a run is presented after its request passes the input register, the
// ROM lookup stage, the align stage and the serialiser output register. Throughput: one
// request per cycle while every character passes through and out_stall_i is low; a run
// occupies the serialiser until its final byte leaves, and the stages in front of it
// fill and then stall the text channel back to its sender.
// Reset clears every valid bit, so the pipeline comes up empty with no output pending.
// While out_stall_i is high the output byte and its flags hold, and requests keep being
// taken until the stages in front of the serialiser are full.
module macroman_html_entity_escaper_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       text_valid_i,
  output logic       text_stall_o,
  input  logic [7:0] text_byte_i,
  input  logic       text_end_i,
  output logic       out_valid_o,
  input  logic       out_stall_i,
  output logic [7:0] out_byte_o,
  output logic       run_last_o,
  output logic       text_last_o
);
  import mhe_pkg::*;

  // Input register: breaks the sender's timing from the ROM path.
  logic       in_valid_q;
  logic [7:0] in_byte_q;
  logic       in_end_q;
  logic       lk_stall;

  // Between the lookup and align stages.
  logic       lk_valid;
  lk_t        lk_data;
  logic       al_stall;

  // Between the align stage and the serialiser.
  logic       al_valid;
  run_t       al_run;
  logic       ser_stall;

  assign text_stall_o = in_valid_q & lk_stall;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (!text_stall_o) begin
      in_valid_q <= text_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!text_stall_o && text_valid_i) begin
      in_byte_q <= text_byte_i;
      in_end_q  <= text_end_i;
    end
  end

  mhe_lookup u_lookup (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (in_valid_q),
    .byte_i  (in_byte_q),
    .end_i   (in_end_q),
    .stall_o (lk_stall),
    .valid_o (lk_valid),
    .lk_o    (lk_data),
    .stall_i (al_stall)
  );

  mhe_align u_align (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (lk_valid),
    .lk_i    (lk_data),
    .stall_o (al_stall),
    .valid_o (al_valid),
    .run_o   (al_run),
    .stall_i (ser_stall)
  );

  mhe_serial u_serial (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (al_valid),
    .run_i       (al_run),
    .stall_o     (ser_stall),
    .out_valid_o (out_valid_o),
    .out_byte_o  (out_byte_o),
    .run_last_o  (run_last_o),
    .text_last_o (text_last_o),
    .out_stall_i (out_stall_i)
  );

  // A byte taken from the middle of a run must be followed by the rest of that run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && !run_last_o |=> out_valid_o)
    else $error("run broken off before its final byte");

  // The text channel is only held back when the input register is occupied.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_valid_q |-> !text_stall_o)
    else $error("text channel stalled with an empty input register");

  // The text mark can only fall on the byte that closes a run.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && text_last_o |-> run_last_o)
    else $error("text end marked on a byte that does not close its run");

  // Every run longer than one byte opens with an ampersand.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_stall_i && run_last_o && al_valid && (al_run.len != 4'd1)
      |=> out_byte_o == ChAmp)
    else $error("expanded run does not open with an ampersand");

endmodule
